// ----- sv/hswp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hswp_pkg;

	typedef enum logic [1:0] {
		MODE_PASS,
		MODE_WATER,
		MODE_UP,
		MODE_DOWN
	} mode_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

	localparam logic signed [10:0] EMPTY_HEIGHT = -11'sd128;
	localparam logic [6:0]  PCT_FULL    = 7'd100;
	localparam logic [6:0]  OPACITY_MAX = 7'd85;
	localparam logic [3:0]  OPACITY_STEP = 4'd15;
	localparam logic [11:0] DEPTH_SAT   = 12'd6;
	localparam logic [7:0]  LEVEL_RESET = 8'd100;
	localparam logic [7:0]  CHAN_MAX    = 8'hFF;
	// floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every 16-bit x
	localparam logic [16:0] RECIP_100   = 17'd83887;
	localparam int          RECIP_SHIFT = 23;

endpackage

`default_nettype wire

// ----- sv/hswp_chan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hswp_chan (
	input  logic              clk,
	input  hswp_pkg::pipe_en_t en,
	input  hswp_pkg::mode_t   mode,
	input  logic [6:0]        opacity,
	input  logic [7:0]        level,
	input  logic [7:0]        color,
	input  logic [7:0]        water,
	output logic [7:0]        result
);
	import hswp_pkg::*;

	logic [15:0] x_next;
	logic [15:0] x_s2;
	mode_t       mode_s2;
	logic [7:0]  level_s2;

	logic [32:0] prod_full;
	logic        sat_next;
	logic [3:0]  qhi_next;
	logic [7:0]  rem_next;

	logic [9:0]  scaled_s3;
	logic        sat_s3;
	logic [3:0]  qhi_s3;
	logic [7:0]  rem_s3;
	logic [3:0]  xlo_s3;
	logic [7:0]  pass_s3;
	mode_t       mode_s3;
	logic [7:0]  level_s3;

	logic [3:0]  qlo_next;
	logic [7:0]  res_next;
	logic [7:0]  res_s4;

	// numerator per mode
	always_comb begin
		case (mode)
			MODE_WATER: x_next = 16'(16'(PCT_FULL - opacity) * 16'(color))
				+ 16'(16'(opacity) * 16'(water));
			MODE_UP:    x_next = 16'(16'(color) * 16'(level));
			MODE_DOWN:  x_next = 16'(16'(color) * 16'(PCT_FULL));
			default:    x_next = 16'(color);
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			x_s2     <= x_next;
			mode_s2  <= mode;
			level_s2 <= level;
		end
	end

	// divide by 100 through reciprocal; divide by level, upper quotient bits
	assign prod_full = 33'(x_s2) * 33'(RECIP_100);
	assign sat_next  = x_s2[15:8] >= level_s2;

	always_comb begin
		logic [8:0] t;
		rem_next = x_s2[15:8];
		qhi_next = '0;
		t        = '0;
		for (int i = 0; i < 4; i++) begin
			t = {rem_next, x_s2[7 - i]};
			if (t >= {1'b0, level_s2}) begin
				rem_next     = 8'(t - {1'b0, level_s2});
				qhi_next[3 - i] = 1'b1;
			end else begin
				rem_next = t[7:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			scaled_s3 <= prod_full[RECIP_SHIFT +: 10];
			sat_s3    <= sat_next;
			qhi_s3    <= qhi_next;
			rem_s3    <= rem_next;
			xlo_s3    <= x_s2[3:0];
			pass_s3   <= x_s2[7:0];
			mode_s3   <= mode_s2;
			level_s3  <= level_s2;
		end
	end

	// lower quotient bits
	always_comb begin
		logic [8:0] t;
		logic [7:0] r;
		r        = rem_s3;
		qlo_next = '0;
		t        = '0;
		for (int i = 0; i < 4; i++) begin
			t = {r, xlo_s3[3 - i]};
			if (t >= {1'b0, level_s3}) begin
				r               = 8'(t - {1'b0, level_s3});
				qlo_next[3 - i] = 1'b1;
			end else begin
				r = t[7:0];
			end
		end
	end

	always_comb begin
		case (mode_s3)
			MODE_WATER: res_next = scaled_s3[7:0];
			MODE_UP:    res_next = (scaled_s3 > 10'(CHAN_MAX)) ? CHAN_MAX : scaled_s3[7:0];
			MODE_DOWN:  res_next = sat_s3 ? CHAN_MAX : {qhi_s3, qlo_next};
			default:    res_next = pass_s3;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			res_s4 <= res_next;
		end
	end

	assign result = res_s4;

endmodule

`default_nettype wire

// ----- sv/height_shade_water_pixel.sv -----
// Per-pixel hillshade and water tint for a streamed height map.
//
// Input channel s_axis_*: one map pixel per item. Output channel m_axis_*:
// one colour per item, in input order. Items are taken in every cycle in
// which the output side keeps up; throughput is one pixel per clock.
// Each item passes four register stages, the first loaded at the accepting
// edge, and m_axis_tvalid rises once it is loaded into the fourth. The
// stages are decode, numerator, reciprocal multiply and first
// half of the level divide, then the second half of the divide and the final
// select. The three channels run in parallel through their own multipliers
// and dividers.
// Each stage holds its item while the next one is full and stalled, and
// bubbles are squeezed out, so a stalled receiver only blocks the input
// once all four stages are occupied.
// cfg_we writes shade_level from cfg_wdata; write it only while no item is
// in flight. A level of zero behaves as one.
// Reset (arst_n low) empties the pipeline and sets shade_level to 100.
`timescale 1ns / 1ps
`default_nettype none

module height_shade_water_pixel (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pixel_rgb[23:0], top_height[34:24], floor_height[45:35], water_argb[77:46],
	// side_x_height[88:78], side_z_height[99:89], zero fill [103:100]
	input  logic [103:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// shaded_rgb[23:0]
	output logic [23:0]  m_axis_tdata
);
	import hswp_pkg::*;

	logic [7:0] shade_level_q;

	logic [23:0]        in_rgb;
	logic signed [10:0] in_top;
	logic signed [10:0] in_floor;
	logic [31:0]        in_water;
	logic signed [10:0] in_sx;
	logic signed [10:0] in_sz;

	logic signed [11:0] depth;
	logic [6:0]         opacity_next;
	logic signed [10:0] nx;
	logic signed [10:0] nz;
	logic signed [11:0] nsum;
	logic signed [11:0] top2;
	mode_t              mode_next;

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic        load_1, load_2, load_3, load_4;
	mode_t       mode_s1;
	logic [6:0]  opacity_s1;
	logic [7:0]  level_s1;
	logic [23:0] rgb_s1;
	logic [23:0] water_s1;
	pipe_en_t    en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shade_level_q <= LEVEL_RESET;
		end else if (cfg_we) begin
			shade_level_q <= cfg_wdata;
		end
	end

	assign in_rgb   = s_axis_tdata[23:0];
	assign in_top   = s_axis_tdata[34:24];
	assign in_floor = s_axis_tdata[45:35];
	assign in_water = s_axis_tdata[77:46];
	assign in_sx    = s_axis_tdata[88:78];
	assign in_sz    = s_axis_tdata[99:89];

	// decode
	assign depth = 12'(in_top) - 12'(in_floor);
	assign nx    = (in_sx == EMPTY_HEIGHT) ? in_top : in_sx;
	assign nz    = (in_sz == EMPTY_HEIGHT) ? in_top : in_sz;
	assign nsum  = 12'(nx) + 12'(nz);
	assign top2  = {in_top, 1'b0};

	always_comb begin
		if (depth[11]) begin
			opacity_next = '0;
		end else if (depth >= $signed(DEPTH_SAT)) begin
			opacity_next = OPACITY_MAX;
		end else begin
			opacity_next = 7'(depth[2:0]) * 7'(OPACITY_STEP);
		end
	end

	always_comb begin
		if (in_water != '0) begin
			mode_next = MODE_WATER;
		end else if (in_top == EMPTY_HEIGHT) begin
			mode_next = MODE_PASS;
		end else if (top2 > nsum) begin
			mode_next = MODE_UP;
		end else if (top2 < nsum) begin
			mode_next = MODE_DOWN;
		end else begin
			mode_next = MODE_PASS;
		end
	end

	// stage handshake: a stage loads when empty or when its item moves on
	assign load_4 = !valid_s4 || m_axis_tready;
	assign load_3 = !valid_s3 || load_4;
	assign load_2 = !valid_s2 || load_3;
	assign load_1 = !valid_s1 || load_2;

	assign s_axis_tready = load_1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (load_1) valid_s1 <= s_axis_tvalid;
			if (load_2) valid_s2 <= valid_s1;
			if (load_3) valid_s3 <= valid_s2;
			if (load_4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (load_1) begin
			mode_s1    <= mode_next;
			opacity_s1 <= opacity_next;
			level_s1   <= (shade_level_q == '0) ? 8'd1 : shade_level_q;
			rgb_s1     <= in_rgb;
			water_s1   <= in_water[23:0];
		end
	end

	assign en.s2 = load_2;
	assign en.s3 = load_3;
	assign en.s4 = load_4;

	for (genvar k = 0; k < 3; k++) begin : g_chan
		hswp_chan u_chan (
			.clk     (clk),
			.en      (en),
			.mode    (mode_s1),
			.opacity (opacity_s1),
			.level   (level_s1),
			.color   (rgb_s1[8 * k +: 8]),
			.water   (water_s1[8 * k +: 8]),
			.result  (m_axis_tdata[8 * k +: 8])
		);
	end

	assign m_axis_tvalid = valid_s4;

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input blocked while output drains");

	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output stage");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load_2 |=> valid_s1 && $stable(mode_s1) && $stable(rgb_s1))
		else $error("stage 1 item lost under stall");

endmodule

`default_nettype wire

// ----- tb/sv/tb_height_shade_water_pixel.sv -----
`timescale 1ns / 1ps

module tb_height_shade_water_pixel;
	import hswp_pkg::*;

	typedef struct {
		logic [23:0]        rgb;
		logic signed [10:0] top;
		logic signed [10:0] flo;
		logic [31:0]        water;
		logic signed [10:0] side_x;
		logic signed [10:0] side_z;
	} map_pixel_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [7:0]   cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [23:0]  m_axis_tdata;

	logic [23:0] expected_rgb[$];
	logic [7:0]  shade_level_now;
	int          fail_count;
	int          send_idle_pct;
	int          recv_idle_pct;

	height_shade_water_pixel DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [23:0] predict_shade(map_pixel_t px, logic [7:0] level);
		int          depth;
		int          pct;
		int          lvl;
		int          nx;
		int          nz;
		int          cur2;
		int          c;
		int          w;
		logic [23:0] res;
		res = px.rgb;
		if (px.water != 32'd0) begin
			depth = int'(px.top) - int'(px.flo);
			if (depth < 0)
				depth = 0;
			pct = depth * 15;
			if (pct > 85)
				pct = 85;
			for (int k = 0; k < 3; k++) begin
				c = int'(px.rgb[8*k +: 8]);
				w = int'(px.water[8*k +: 8]);
				res[8*k +: 8] = 8'(((100 - pct) * c + pct * w) / 100);
			end
		end else if (px.top != EMPTY_HEIGHT) begin
			lvl = (level == 8'd0) ? 1 : int'(level);
			nx = (px.side_x == EMPTY_HEIGHT) ? int'(px.top) : int'(px.side_x);
			nz = (px.side_z == EMPTY_HEIGHT) ? int'(px.top) : int'(px.side_z);
			cur2 = 2 * int'(px.top);
			if (cur2 != nx + nz) begin
				for (int k = 0; k < 3; k++) begin
					c = int'(px.rgb[8*k +: 8]);
					c = (cur2 > nx + nz) ? c * lvl / 100 : c * 100 / lvl;
					res[8*k +: 8] = (c > 255) ? 8'hFF : 8'(c);
				end
			end
		end
		return res;
	endfunction

	function automatic logic [23:0] rand_rgb();
		case ($urandom_range(7))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic signed [10:0] rand_height(logic signed [10:0] base);
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return EMPTY_HEIGHT;
		if (r < 20)
			return 11'($urandom);
		if (r < 25)
			return $urandom_range(1) ? 11'sd1023 : -11'sd1024;
		return base + 11'($urandom_range(8)) - 11'sd4;
	endfunction

	function automatic map_pixel_t rand_water_pixel();
		map_pixel_t px;
		px.rgb = rand_rgb();
		px.top = rand_height(11'($urandom_range(40)) - 11'sd20);
		case ($urandom_range(9))
			0: px.flo = 11'($urandom);
			1: px.flo = px.top + 11'($urandom_range(20));
			default: px.flo = px.top - 11'($urandom_range(8));
		endcase
		case ($urandom_range(9))
			0: px.water = {8'($urandom_range(1, 255)), 24'h0};
			1: px.water = {8'h00, 24'($urandom_range(1, 24'hFFFFFF))};
			2: px.water = 32'hFFFFFFFF;
			default: px.water = $urandom;
		endcase
		if (px.water == 32'd0)
			px.water = 32'd1;
		px.side_x = 11'($urandom);
		px.side_z = 11'($urandom);
		return px;
	endfunction

	function automatic map_pixel_t rand_land_pixel();
		map_pixel_t px;
		px.rgb = rand_rgb();
		px.top = ($urandom_range(19) == 0) ? EMPTY_HEIGHT : rand_height(11'($urandom));
		px.flo = 11'($urandom);
		px.water = 32'd0;
		px.side_x = rand_height(px.top);
		px.side_z = rand_height(px.top);
		return px;
	endfunction

	task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
		$display("%0t: %s shaded_rgb got %06h want %06h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic queue_result(logic [23:0] rgb);
		expected_rgb.insert(expected_rgb.size(), rgb);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_rgb.size() == 0)
				report_mismatch("unexpected", m_axis_tdata, 24'h0);
			else if (m_axis_tdata !== expected_rgb[0]) begin
				report_mismatch("mismatch", m_axis_tdata, expected_rgb[0]);
				void'(expected_rgb.pop_front());
			end else
				void'(expected_rgb.pop_front());
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_pixel(map_pixel_t px);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tdata = {4'b0, px.side_z, px.side_x, px.water, px.flo, px.top, px.rgb};
		s_axis_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		queue_result(predict_shade(px, shade_level_now));
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_rgb.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_shade_level(logic [7:0] level);
		drain_results();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = level;
		@(negedge clk);
		cfg_we = 1'b0;
		shade_level_now = level;
	endtask

	task automatic send_fields(logic [23:0] rgb, logic signed [10:0] top, logic signed [10:0] flo,
			logic [31:0] water, logic signed [10:0] sx, logic signed [10:0] sz);
		map_pixel_t px;
		px.rgb = rgb;
		px.top = top;
		px.flo = flo;
		px.water = water;
		px.side_x = sx;
		px.side_z = sz;
		send_pixel(px);
	endtask

	task automatic test_directed_cases();
		// empty pixel, with zero and with extreme neighbor heights
		send_fields(24'hFFFFFF, EMPTY_HEIGHT, 11'sd0, 32'd0, 11'sd0, 11'sd0);
		send_fields(24'h123456, EMPTY_HEIGHT, 11'sd0, 32'd0, 11'sd1023, -11'sd1024);
		// water: deep, empty-height column, alpha only, negative depth, each step
		send_fields(24'h000000, EMPTY_HEIGHT, -11'sd1024, 32'hFFFFFFFF, 11'sd0, 11'sd0);
		send_fields(24'hFFFFFF, 11'sd1023, -11'sd1024, 32'h00000000 | 32'h00000001,
			11'sd0, 11'sd0);
		send_fields(24'hA5C37E, 11'sd4, 11'sd4, 32'hFF000000, 11'sd0, 11'sd0);
		send_fields(24'hFFFFFF, -11'sd1024, 11'sd1023, 32'h00102030, 11'sd0, 11'sd0);
		for (int d = 1; d <= 6; d++)
			send_fields(24'hFF8000, 11'(d), 11'sd0, 32'h0000FFFF, -11'sd128, -11'sd128);
		// hillshade: higher, lower, level, absent neighbors
		send_fields(24'hFFFFFF, 11'sd1023, -11'sd1024, 32'd0, -11'sd1024, -11'sd1024);
		send_fields(24'hFFFFFF, -11'sd1024, 11'sd1023, 32'd0, 11'sd1023, 11'sd1023);
		send_fields(24'h808080, 11'sd5, 11'sd0, 32'd0, 11'sd4, 11'sd6);
		send_fields(24'h808080, 11'sd10, 11'sd0, 32'd0, EMPTY_HEIGHT, EMPTY_HEIGHT);
		send_fields(24'h808080, 11'sd10, 11'sd0, 32'd0, EMPTY_HEIGHT, 11'sd0);
		send_fields(24'h808080, 11'sd10, 11'sd0, 32'd0, 11'sd30, EMPTY_HEIGHT);
		set_shade_level(8'd255);
		send_fields(24'hFFFFFF, 11'sd1, 11'sd0, 32'd0, 11'sd0, 11'sd0);
		send_fields(24'h64C801, -11'sd1, 11'sd0, 32'd0, 11'sd0, 11'sd0);
		set_shade_level(8'd1);
		send_fields(24'h030201, -11'sd1, 11'sd0, 32'd0, 11'sd0, 11'sd0);
		send_fields(24'hFF6401, 11'sd1, 11'sd0, 32'd0, 11'sd0, 11'sd0);
		set_shade_level(8'd0);
		send_fields(24'h010203, -11'sd1, 11'sd0, 32'd0, 11'sd0, 11'sd0);
		send_fields(24'hFFFFFF, 11'sd1, 11'sd0, 32'd0, 11'sd0, 11'sd0);
	endtask

	task automatic test_water_blend(int count);
		repeat (count) send_pixel(rand_water_pixel());
	endtask

	task automatic test_hillshade(int count);
		repeat (count) send_pixel(rand_land_pixel());
	endtask

	task automatic test_mixed_pixels(int count);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				drain_results();
			send_pixel($urandom_range(2) == 0 ? rand_water_pixel() : rand_land_pixel());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		fail_count = 0;
		shade_level_now = LEVEL_RESET;
		send_idle_pct = 19;
		recv_idle_pct = 88;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			set_shade_level(8'($urandom_range(1, 255)));
			test_water_blend(150);
			set_shade_level(phase == 1 ? 8'd100 : 8'd255);
			test_hillshade(150);
			set_shade_level(phase == 0 ? 8'd1 : 8'($urandom_range(1, 255)));
			test_mixed_pixels(150);
		end

		drain_results();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
